>>> sv/bsa_pkg.sv
// Shared types, constants and helper functions of the safety allocator.
`default_nettype none

package bsa_pkg;

    localparam int CUSTOMERS    = 32;
    localparam int UNIT_BITS    = 8;
    localparam int RTYPES       = 4;
    localparam int FIELD_W      = 8;
    localparam int CUST_FIELD_W = 5;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CUST_W       = $clog2(CUSTOMERS);
    localparam int SAT_W        = (UNIT_BITS > FIELD_W) ? UNIT_BITS : FIELD_W;

    typedef logic [UNIT_BITS-1:0]    unit_t;
    typedef unit_t [RTYPES-1:0]      units_t;
    typedef logic [FIELD_W-1:0]      field_t;
    typedef field_t [RTYPES-1:0]     fields_t;
    typedef logic [CUST_W-1:0]       cust_idx_t;
    typedef logic [CUST_FIELD_W-1:0] cust_field_t;
    typedef logic [FUNC_W-1:0]       func_t;
    typedef logic [STATUS_W-1:0]     status_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    typedef struct packed {
        units_t claim;
        units_t held;
    } row_t;

    typedef struct packed {
        logic capture;
        logic rd_item;
        logic apply;
        logic scan;
        logic decide;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_go;
        logic scan_last;
    } sts_t;

    localparam unit_t     UNIT_MAX  = '1;
    localparam cust_idx_t CUST_LAST = cust_idx_t'(CUSTOMERS - 1);

    localparam func_t FN_CLAIM   = 2'd0;
    localparam func_t FN_REQUEST = 2'd1;
    localparam func_t FN_RELEASE = 2'd2;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_UNSAFE = 3'd1;
    localparam status_t ST_NEED   = 3'd2;
    localparam status_t ST_FREE   = 3'd3;
    localparam status_t ST_HELD   = 3'd4;

    localparam field_t RESET_UNITS_0 = 8'd11;
    localparam field_t RESET_UNITS_1 = 8'd10;
    localparam field_t RESET_UNITS_2 = 8'd12;
    localparam field_t RESET_UNITS_3 = 8'd13;

    function automatic unit_t sat_field(field_t v);
        logic [SAT_W-1:0] x;
        x = SAT_W'(v);
        if (x > SAT_W'(UNIT_MAX))
            return UNIT_MAX;
        return x[UNIT_BITS-1:0];
    endfunction

    function automatic unit_t sat_add(unit_t a, unit_t b);
        logic [UNIT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[UNIT_BITS])
            return UNIT_MAX;
        return s[UNIT_BITS-1:0];
    endfunction

    function automatic units_t free_reset();
        units_t v;
        v[0] = sat_field(RESET_UNITS_0);
        v[1] = sat_field(RESET_UNITS_1);
        v[2] = sat_field(RESET_UNITS_2);
        v[3] = sat_field(RESET_UNITS_3);
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/bsa_ctrl.sv
// Sequencing state machine of the safety allocator.
`default_nettype none

module bsa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bsa_pkg::cmd_t      cmd,
    input  wire bsa_pkg::sts_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_item = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.apply = 1'b1;
                if (sts.scan_go)
                    state_next = S_SCAN;
                else
                    state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/bsa_dpath.sv
// Datapath: customer row memory, free pool, safety scan and result registers.
`default_nettype none

module bsa_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bsa_pkg::cmd_t         cmd,
    output bsa_pkg::sts_t              sts,
    input  wire bsa_pkg::func_t        in_func,
    input  wire bsa_pkg::cust_field_t  in_customer,
    input  wire bsa_pkg::fields_t      in_amount,
    input  wire logic                  cfg_we,
    input  wire bsa_pkg::cfg_idx_t     cfg_idx,
    input  wire bsa_pkg::field_t       cfg_value,
    output bsa_pkg::status_t           out_status,
    output bsa_pkg::cust_field_t       out_blocker,
    output bsa_pkg::fields_t           out_free
);

    bsa_pkg::row_t mem_array [bsa_pkg::CUSTOMERS];
    bsa_pkg::row_t rd_data_reg;

    logic [bsa_pkg::CUSTOMERS-1:0] valid_reg, valid_next;
    logic                          rd_hit_reg, rd_hit_next;

    bsa_pkg::func_t       func_reg, func_next;
    bsa_pkg::cust_field_t cust_reg, cust_next;
    bsa_pkg::units_t      amt_reg, amt_next;
    bsa_pkg::units_t      free_reg, free_next;
    bsa_pkg::row_t        save_reg, save_next;
    bsa_pkg::units_t      work_reg, work_next;
    logic [bsa_pkg::CUSTOMERS-1:0] done_reg, done_next;
    bsa_pkg::cust_idx_t   rd_row_reg, rd_row_next;
    bsa_pkg::cust_idx_t   rd_pass_reg, rd_pass_next;
    logic                 ev_valid_reg, ev_valid_next;
    bsa_pkg::cust_idx_t   ev_row_reg, ev_row_next;
    logic                 ev_last_reg, ev_last_next;
    logic                 found_reg, found_next;
    bsa_pkg::cust_idx_t   blk_reg, blk_next;
    bsa_pkg::status_t     status_reg, status_next;
    bsa_pkg::cust_idx_t   blocker_reg, blocker_next;
    bsa_pkg::status_t     out_status_reg, out_status_next;
    bsa_pkg::cust_field_t out_blocker_reg, out_blocker_next;
    bsa_pkg::fields_t     out_free_reg, out_free_next;

    bsa_pkg::cust_idx_t cust_addr;
    bsa_pkg::cust_idx_t rd_addr;
    logic               rd_en;
    logic               wr_en;
    bsa_pkg::row_t      wr_data;
    bsa_pkg::row_t      row_vis;
    bsa_pkg::units_t    need;
    logic               in_range;
    logic               over_need;
    logic               over_free;
    logic               over_held;
    logic               fits;
    logic               done_bit;

    assign cust_addr = bsa_pkg::cust_idx_t'(cust_reg);
    assign in_range  = (32'(cust_reg) < 32'(bsa_pkg::CUSTOMERS));
    assign rd_addr   = cmd.scan ? rd_row_reg : cust_addr;
    assign rd_en     = cmd.scan | cmd.rd_item;
    assign row_vis   = rd_hit_reg ? rd_data_reg : '0;
    assign done_bit  = done_reg[ev_row_reg];

    always_comb
    begin
        over_need = 1'b0;
        over_free = 1'b0;
        over_held = 1'b0;
        fits      = 1'b1;
        for (int r = 0; r < bsa_pkg::RTYPES; r++)
        begin
            need[r] = row_vis.claim[r] - row_vis.held[r];
            if (amt_reg[r] > need[r])
                over_need = 1'b1;
            if (amt_reg[r] > free_reg[r])
                over_free = 1'b1;
            if (amt_reg[r] > row_vis.held[r])
                over_held = 1'b1;
            if (need[r] > work_reg[r])
                fits = 1'b0;
        end
    end

    assign sts.scan_go   = in_range && (func_reg == bsa_pkg::FN_REQUEST) && !over_need
                           && !over_free;
    assign sts.scan_last = (rd_row_reg == bsa_pkg::CUST_LAST)
                           && (rd_pass_reg == bsa_pkg::CUST_LAST);

    always_comb
    begin
        valid_next       = valid_reg;
        rd_hit_next      = rd_hit_reg;
        func_next        = func_reg;
        cust_next        = cust_reg;
        amt_next         = amt_reg;
        free_next        = free_reg;
        save_next        = save_reg;
        work_next        = work_reg;
        done_next        = done_reg;
        rd_row_next      = rd_row_reg;
        rd_pass_next     = rd_pass_reg;
        found_next       = found_reg;
        blk_next         = blk_reg;
        status_next      = status_reg;
        blocker_next     = blocker_reg;
        out_status_next  = out_status_reg;
        out_blocker_next = out_blocker_reg;
        out_free_next    = out_free_reg;
        wr_en            = 1'b0;
        wr_data          = save_reg;

        if (rd_en)
            rd_hit_next = valid_reg[rd_addr];

        if (cfg_we)
            free_next[cfg_idx] = bsa_pkg::sat_field(cfg_value);

        if (cmd.capture)
        begin
            func_next = in_func;
            cust_next = in_customer;
            for (int r = 0; r < bsa_pkg::RTYPES; r++)
                amt_next[r] = bsa_pkg::sat_field(in_amount[r]);
        end

        if (cmd.apply)
        begin
            save_next    = row_vis;
            status_next  = bsa_pkg::ST_OK;
            blocker_next = '0;
            done_next    = '0;
            rd_row_next  = '0;
            rd_pass_next = '0;
            found_next   = 1'b0;
            blk_next     = '0;
            if (in_range)
            begin
                case (func_reg)
                    bsa_pkg::FN_CLAIM:
                    begin
                        wr_en        = 1'b1;
                        wr_data.claim = amt_reg;
                        wr_data.held  = '0;
                        for (int r = 0; r < bsa_pkg::RTYPES; r++)
                            free_next[r] = bsa_pkg::sat_add(free_reg[r], row_vis.held[r]);
                    end
                    bsa_pkg::FN_REQUEST:
                    begin
                        if (over_need)
                            status_next = bsa_pkg::ST_NEED;
                        else if (over_free)
                            status_next = bsa_pkg::ST_FREE;
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data.claim = row_vis.claim;
                            for (int r = 0; r < bsa_pkg::RTYPES; r++)
                            begin
                                wr_data.held[r] = row_vis.held[r] + amt_reg[r];
                                free_next[r]    = free_reg[r] - amt_reg[r];
                                work_next[r]    = free_reg[r] - amt_reg[r];
                            end
                        end
                    end
                    bsa_pkg::FN_RELEASE:
                    begin
                        if (over_held)
                            status_next = bsa_pkg::ST_HELD;
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data.claim = row_vis.claim;
                            for (int r = 0; r < bsa_pkg::RTYPES; r++)
                            begin
                                wr_data.held[r] = row_vis.held[r] - amt_reg[r];
                                free_next[r]    = bsa_pkg::sat_add(free_reg[r], amt_reg[r]);
                            end
                        end
                    end
                    default:
                    begin
                        status_next = bsa_pkg::ST_OK;
                    end
                endcase
            end
        end

        if (cmd.scan)
        begin
            if (rd_row_reg == bsa_pkg::CUST_LAST)
            begin
                rd_row_next  = '0;
                rd_pass_next = rd_pass_reg + 1'b1;
            end
            else
            begin
                rd_row_next = rd_row_reg + 1'b1;
            end
        end
        ev_valid_next = cmd.scan;
        ev_row_next   = rd_row_reg;
        ev_last_next  = (rd_pass_reg == bsa_pkg::CUST_LAST);

        if (ev_valid_reg && !done_bit)
        begin
            if (fits)
            begin
                done_next[ev_row_reg] = 1'b1;
                for (int r = 0; r < bsa_pkg::RTYPES; r++)
                    work_next[r] = bsa_pkg::sat_add(work_reg[r], row_vis.held[r]);
            end
            else if (ev_last_reg && !found_reg)
            begin
                found_next = 1'b1;
                blk_next   = ev_row_reg;
            end
        end

        if (cmd.decide && found_reg)
        begin
            wr_en        = 1'b1;
            wr_data      = save_reg;
            status_next  = bsa_pkg::ST_UNSAFE;
            blocker_next = blk_reg;
            for (int r = 0; r < bsa_pkg::RTYPES; r++)
                free_next[r] = free_reg[r] + amt_reg[r];
        end

        if (wr_en)
            valid_next[cust_addr] = 1'b1;

        if (cmd.load_out)
        begin
            out_status_next  = status_reg;
            out_blocker_next = bsa_pkg::cust_field_t'(blocker_reg);
            for (int r = 0; r < bsa_pkg::RTYPES; r++)
                out_free_next[r] = bsa_pkg::field_t'(free_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_array[cust_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_array[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            rd_hit_reg      <= 1'b0;
            func_reg        <= bsa_pkg::FN_CLAIM;
            cust_reg        <= '0;
            amt_reg         <= '0;
            free_reg        <= bsa_pkg::free_reset();
            save_reg        <= '0;
            work_reg        <= '0;
            done_reg        <= '0;
            rd_row_reg      <= '0;
            rd_pass_reg     <= '0;
            ev_valid_reg    <= 1'b0;
            ev_row_reg      <= '0;
            ev_last_reg     <= 1'b0;
            found_reg       <= 1'b0;
            blk_reg         <= '0;
            status_reg      <= bsa_pkg::ST_OK;
            blocker_reg     <= '0;
            out_status_reg  <= bsa_pkg::ST_OK;
            out_blocker_reg <= '0;
            out_free_reg    <= '0;
        end
        else
        begin
            valid_reg       <= valid_next;
            rd_hit_reg      <= rd_hit_next;
            func_reg        <= func_next;
            cust_reg        <= cust_next;
            amt_reg         <= amt_next;
            free_reg        <= free_next;
            save_reg        <= save_next;
            work_reg        <= work_next;
            done_reg        <= done_next;
            rd_row_reg      <= rd_row_next;
            rd_pass_reg     <= rd_pass_next;
            ev_valid_reg    <= ev_valid_next;
            ev_row_reg      <= ev_row_next;
            ev_last_reg     <= ev_last_next;
            found_reg       <= found_next;
            blk_reg         <= blk_next;
            status_reg      <= status_next;
            blocker_reg     <= blocker_next;
            out_status_reg  <= out_status_next;
            out_blocker_reg <= out_blocker_next;
            out_free_reg    <= out_free_next;
        end
    end

    assign out_status  = out_status_reg;
    assign out_blocker = out_blocker_reg;
    assign out_free    = out_free_reg;

endmodule

`default_nettype wire

>>> sv/bankers_safety_allocator_top.sv
// Top level of the safety allocator: controller, datapath and port wiring.
//
//  channel  handshake              word
//  in       in_valid / in_ready    func, customer, amount_0..3
//  out      out_valid / out_ready  status, blocking_customer, free_0..3
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time: claim, release and refused requests pass read, load and finish;
// a request that reaches the safety scan also passes scan, drain and decide, one row
// visit per cycle; in_ready is high again as soon as out_valid rises.
// A finished result waits in the output register while the next word is taken;
// only that word's own result waits on out_ready.
// Reset marks all rows empty and reloads the free pool; no clearing pass is needed.
`default_nettype none

module bankers_safety_allocator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bsa_pkg::FUNC_W-1:0]    func,
    input  wire logic [bsa_pkg::CUST_FIELD_W-1:0] customer,
    input  wire logic [bsa_pkg::FIELD_W-1:0]   amount_0,
    input  wire logic [bsa_pkg::FIELD_W-1:0]   amount_1,
    input  wire logic [bsa_pkg::FIELD_W-1:0]   amount_2,
    input  wire logic [bsa_pkg::FIELD_W-1:0]   amount_3,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bsa_pkg::STATUS_W-1:0]       status,
    output logic [bsa_pkg::CUST_FIELD_W-1:0]   blocking_customer,
    output logic [bsa_pkg::FIELD_W-1:0]        free_0,
    output logic [bsa_pkg::FIELD_W-1:0]        free_1,
    output logic [bsa_pkg::FIELD_W-1:0]        free_2,
    output logic [bsa_pkg::FIELD_W-1:0]        free_3,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsa_pkg::FIELD_W-1:0]   cfg_data
);

    bsa_pkg::cmd_t    cmd;
    bsa_pkg::sts_t    sts;
    bsa_pkg::fields_t in_amount;
    bsa_pkg::fields_t out_free;

    assign cfg_ready = 1'b1;

    assign in_amount[0] = amount_0;
    assign in_amount[1] = amount_1;
    assign in_amount[2] = amount_2;
    assign in_amount[3] = amount_3;

    assign free_0 = out_free[0];
    assign free_1 = out_free[1];
    assign free_2 = out_free[2];
    assign free_3 = out_free[3];

    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bsa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (func),
        .in_customer (customer),
        .in_amount   (in_amount),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_value   (cfg_data),
        .out_status  (status),
        .out_blocker (blocking_customer),
        .out_free    (out_free)
    );

endmodule

`default_nettype wire

>>> sv/bsa_checker.sv
// Port-level assertions for the safety allocator, bound to the top level.
`default_nettype none

module bsa_port_props (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [bsa_pkg::STATUS_W-1:0]     status,
    input wire logic [bsa_pkg::CUST_FIELD_W-1:0] blocking_customer,
    input wire logic [bsa_pkg::FIELD_W-1:0]      free_0
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(blocking_customer) && $stable(free_0))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == bsa_pkg::ST_OK) || (status == bsa_pkg::ST_UNSAFE)
            || (status == bsa_pkg::ST_NEED) || (status == bsa_pkg::ST_FREE)
            || (status == bsa_pkg::ST_HELD))
        else $error("undefined status code");

    a_blocker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != bsa_pkg::ST_UNSAFE) |-> blocking_customer == '0)
        else $error("blocking customer set on a word that was not unsafe");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

endmodule

bind bankers_safety_allocator_top bsa_port_props u_bsa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .blocking_customer (blocking_customer),
    .free_0            (free_0)
);

`default_nettype wire

>>> test/bsa_checker.sv
// Checker for the safety allocator: watches all three channels, predicts each result and compares.
module bsa_checker
    import bsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  func_t       func,
    input  cust_field_t customer,
    input  field_t      amount_0,
    input  field_t      amount_1,
    input  field_t      amount_2,
    input  field_t      amount_3,
    input  logic        out_valid,
    input  logic        out_ready,
    input  status_t     status,
    input  cust_field_t blocking_customer,
    input  field_t      free_0,
    input  field_t      free_1,
    input  field_t      free_2,
    input  field_t      free_3,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  field_t      cfg_data,
    output int          outstanding,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     code;
        cust_field_t stuck;
        units_t      pool;
    } reply_t;

    units_t free_pool;
    units_t held_units [CUSTOMERS];
    units_t claim_units [CUSTOMERS];
    reply_t replies_due [$];

    function automatic unit_t add_capped(unit_t a, unit_t b);
        int sum;
        sum = int'(a) + int'(b);
        return (sum > int'(UNIT_MAX)) ? UNIT_MAX : unit_t'(sum);
    endfunction

    function automatic bit scan_is_safe(output cust_field_t first_stuck);
        int work [RTYPES];
        bit finished [CUSTOMERS];
        bit fits;
        bit all_done;
        first_stuck = '0;
        all_done = 1'b1;
        for (int r = 0; r < RTYPES; r++)
            work[r] = int'(free_pool[r]);
        for (int c = 0; c < CUSTOMERS; c++)
            finished[c] = 1'b0;
        for (int pass = 0; pass < CUSTOMERS; pass++)
        begin
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                if (!finished[c])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < RTYPES; r++)
                        if (int'(claim_units[c][r]) - int'(held_units[c][r]) > work[r])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (int r = 0; r < RTYPES; r++)
                            work[r] += int'(held_units[c][r]);
                        finished[c] = 1'b1;
                    end
                end
            end
        end
        for (int c = CUSTOMERS - 1; c >= 0; c--)
        begin
            if (!finished[c])
            begin
                first_stuck = cust_field_t'(c);
                all_done = 1'b0;
            end
        end
        return all_done;
    endfunction

    function automatic reply_t apply_op(func_t f, cust_field_t c, units_t amt);
        reply_t rep;
        cust_field_t stuck;
        rep.code = ST_OK;
        rep.stuck = '0;
        case (f)
            FN_CLAIM:
            begin
                for (int r = 0; r < RTYPES; r++)
                begin
                    free_pool[r] = add_capped(free_pool[r], held_units[c][r]);
                    held_units[c][r] = '0;
                    claim_units[c][r] = amt[r];
                end
            end
            FN_REQUEST:
            begin
                for (int r = 0; r < RTYPES; r++)
                    if (amt[r] > claim_units[c][r] - held_units[c][r])
                        rep.code = ST_NEED;
                if (rep.code == ST_OK)
                    for (int r = 0; r < RTYPES; r++)
                        if (amt[r] > free_pool[r])
                            rep.code = ST_FREE;
                if (rep.code == ST_OK)
                begin
                    for (int r = 0; r < RTYPES; r++)
                    begin
                        free_pool[r] -= amt[r];
                        held_units[c][r] += amt[r];
                    end
                    if (!scan_is_safe(stuck))
                    begin
                        for (int r = 0; r < RTYPES; r++)
                        begin
                            free_pool[r] += amt[r];
                            held_units[c][r] -= amt[r];
                        end
                        rep.code = ST_UNSAFE;
                        rep.stuck = stuck;
                    end
                end
            end
            FN_RELEASE:
            begin
                for (int r = 0; r < RTYPES; r++)
                    if (amt[r] > held_units[c][r])
                        rep.code = ST_HELD;
                if (rep.code == ST_OK)
                    for (int r = 0; r < RTYPES; r++)
                    begin
                        held_units[c][r] -= amt[r];
                        free_pool[r] = add_capped(free_pool[r], amt[r]);
                    end
            end
            default:
            begin
            end
        endcase
        rep.pool = free_pool;
        return rep;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            free_pool[0] = RESET_UNITS_0;
            free_pool[1] = RESET_UNITS_1;
            free_pool[2] = RESET_UNITS_2;
            free_pool[3] = RESET_UNITS_3;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                held_units[c] = '0;
                claim_units[c] = '0;
            end
            replies_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                free_pool[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result word with no request pending: status %0d", status);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", 8'(want.code), 8'(status));
                    check_field("blocking_customer", 8'(want.stuck), 8'(blocking_customer));
                    check_field("free_0", want.pool[0], free_0);
                    check_field("free_1", want.pool[1], free_1);
                    check_field("free_2", want.pool[2], free_2);
                    check_field("free_3", want.pool[3], free_3);
                end
            end
            if (in_valid && in_ready)
                replies_due.push_back(apply_op(func, customer,
                                               {amount_3, amount_2, amount_1, amount_0}));
            outstanding <= replies_due.size();
        end
    end

endmodule

>>> test/tb_bankers_safety_allocator_top.sv
// Testbench top for the safety allocator: clock, reset, stimulus, stalls, watchdog and verdict.
module tb_bankers_safety_allocator_top
    import bsa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam func_t FN_UNUSED      = 2'd3;
    localparam int    WATCHDOG_LIMIT = 4096;
    localparam int    DRAIN_CYCLES   = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    func_t       func = FN_CLAIM;
    cust_field_t customer = '0;
    field_t      amount_0 = '0;
    field_t      amount_1 = '0;
    field_t      amount_2 = '0;
    field_t      amount_3 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    status_t     status;
    cust_field_t blocking_customer;
    field_t      free_0;
    field_t      free_1;
    field_t      free_2;
    field_t      free_3;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = '0;
    field_t      cfg_data = '0;

    int      outstanding;
    int      mismatches;
    int      idle_cycles = 0;
    bit      stall_en = 1'b1;
    fields_t claim_shadow [CUSTOMERS];

    bankers_safety_allocator_top u_dut (
        .clk, .rst_n,
        .in_valid, .in_ready, .func, .customer,
        .amount_0, .amount_1, .amount_2, .amount_3,
        .out_valid, .out_ready, .status, .blocking_customer,
        .free_0, .free_1, .free_2, .free_3,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    bsa_checker u_checker (
        .clk, .rst_n,
        .in_valid, .in_ready, .func, .customer,
        .amount_0, .amount_1, .amount_2, .amount_3,
        .out_valid, .out_ready, .status, .blocking_customer,
        .free_0, .free_1, .free_2, .free_3,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .outstanding, .mismatches
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_en && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic fields_t amounts(int a0, int a1, int a2, int a3);
        return {field_t'(a3), field_t'(a2), field_t'(a1), field_t'(a0)};
    endfunction

    // leave in_valid high on return; the next word or settle() decides
    task automatic send_op(func_t f, cust_field_t c, fields_t amt);
        int gap;
        if (stall_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        if (f == FN_CLAIM)
            claim_shadow[c] = amt;
        func <= f;
        customer <= c;
        amount_0 <= amt[0];
        amount_1 <= amt[1];
        amount_2 <= amt[2];
        amount_3 <= amt[3];
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic load_totals(fields_t totals);
        for (int r = 0; r < RTYPES; r++)
        begin
            cfg_index <= cfg_idx_t'(r);
            cfg_data <= totals[r];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_ops(int count, int cap);
        int pick;
        int lim;
        cust_field_t c;
        fields_t amt;
        func_t f;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0)
                c = cust_field_t'($urandom_range(0, 5));
            else
                c = cust_field_t'($urandom_range(0, 31));
            for (int r = 0; r < RTYPES; r++)
                amt[r] = field_t'($urandom_range(0, 255));
            if (pick < 15)
            begin
                f = FN_CLAIM;
                for (int r = 0; r < RTYPES; r++)
                    amt[r] = field_t'($urandom_range(0, cap));
            end
            else if (pick < 65)
            begin
                f = FN_REQUEST;
                for (int r = 0; r < RTYPES; r++)
                begin
                    lim = int'(claim_shadow[c][r]);
                    lim = (pick < 55) ? lim / 2 : lim + 1;
                    if (lim > 255)
                        lim = 255;
                    amt[r] = field_t'($urandom_range(0, lim));
                end
            end
            else if (pick < 85)
            begin
                f = FN_RELEASE;
                for (int r = 0; r < RTYPES; r++)
                    amt[r] = field_t'($urandom_range(0, int'(claim_shadow[c][r]) / 3));
            end
            else
                f = func_t'($urandom_range(0, 3));
            send_op(f, c, amt);
        end
    endtask

    initial
    begin
        fields_t mix;
        for (int c = 0; c < CUSTOMERS; c++)
            claim_shadow[c] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FN_REQUEST, 5'd0, amounts(0, 0, 0, 0));
        send_op(FN_CLAIM, 5'd0, amounts(7, 5, 3, 4));
        send_op(FN_REQUEST, 5'd0, amounts(8, 0, 0, 0));
        send_op(FN_CLAIM, 5'd1, amounts(255, 255, 255, 255));
        send_op(FN_REQUEST, 5'd1, amounts(12, 0, 0, 0));
        send_op(FN_REQUEST, 5'd0, amounts(8, 11, 0, 0));
        send_op(FN_REQUEST, 5'd1, amounts(1, 0, 0, 0));
        send_op(FN_CLAIM, 5'd1, amounts(0, 0, 0, 0));
        send_op(FN_REQUEST, 5'd0, amounts(7, 5, 3, 4));
        send_op(FN_CLAIM, 5'd31, amounts(6, 6, 6, 6));
        send_op(FN_REQUEST, 5'd31, amounts(4, 5, 0, 0));
        send_op(FN_RELEASE, 5'd31, amounts(255, 255, 255, 255));
        send_op(FN_RELEASE, 5'd0, amounts(7, 5, 3, 4));
        send_op(FN_UNUSED, 5'd31, amounts(255, 255, 255, 255));
        send_op(FN_CLAIM, 5'd31, amounts(0, 0, 0, 0));
        send_op(FN_CLAIM, 5'd0, amounts(0, 0, 0, 0));

        // reload a full pool while units are held so returns saturate
        settle();
        load_totals(amounts(255, 255, 255, 255));
        send_op(FN_CLAIM, 5'd2, amounts(255, 255, 255, 255));
        send_op(FN_REQUEST, 5'd2, amounts(200, 100, 255, 1));
        settle();
        load_totals(amounts(255, 255, 255, 255));
        send_op(FN_RELEASE, 5'd2, amounts(100, 100, 255, 1));
        send_op(FN_CLAIM, 5'd2, amounts(0, 0, 0, 0));

        settle();
        load_totals(amounts(255, 255, 255, 255));
        random_ops(150, 100);

        settle();
        load_totals(amounts(0, 0, 0, 0));
        stall_en = 1'b0;
        random_ops(40, 20);

        settle();
        load_totals(amounts(7, 200, 1, 128));
        stall_en = 1'b1;
        random_ops(150, 60);

        settle();
        load_totals(amounts(255, 255, 255, 255));
        random_ops(100, 255);

        settle();
        for (int r = 0; r < RTYPES; r++)
            mix[r] = field_t'($urandom_range(1, 40));
        load_totals(mix);
        stall_en = 1'b0;
        random_ops(80, 40);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
